// ----- src/xsgil_pkg.sv -----
package xsgil_pkg;

   localparam int GRID_DEPTH = 1024;
   localparam int IDX_W      = $clog2(GRID_DEPTH);
   localparam int CNT_W      = $clog2(GRID_DEPTH + 1);

   localparam int E_W     = 57;
   localparam int V_W     = 32;
   localparam int X_W     = 34;
   localparam int BIN_W   = 10;
   localparam int FLAG_W  = 2;
   localparam int RXN_W   = 3;
   localparam int PTS_W   = 11;
   localparam int VROW_W  = 4 * V_W + X_W;
   localparam int PROD_W  = X_W + E_W;
   localparam int STEP_W  = $clog2(X_W);

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic [RXN_W-1:0] RXN_ELASTIC   = 3'd0;
   localparam logic [RXN_W-1:0] RXN_INELASTIC = 3'd1;
   localparam logic [RXN_W-1:0] RXN_FISSION   = 3'd2;
   localparam logic [RXN_W-1:0] RXN_CAPTURE   = 3'd3;

   localparam logic [PTS_W-1:0] PTS_RESET = 11'd2;

   typedef enum logic [FLAG_W-1:0] {
      FLAG_INTERP = 2'd0,
      FLAG_BELOW  = 2'd1,
      FLAG_ABOVE  = 2'd2
   } range_flag_type;

   typedef enum logic [3:0] {
      L_IDLE, L_FIRST, L_LAST, L_SRCH, L_CMP, L_LO, L_HI, L_PREP, L_MULDIV, L_CLAMP, L_OUT
   } lookup_state_type;

   typedef enum logic [1:0] {
      MD_IDLE, MD_MUL, MD_DIV, MD_DONE
   } muldiv_state_type;

   // row layout: total, capture, fission, inelastic, elastic
   function automatic logic [X_W-1:0] xs_select(input logic [VROW_W-1:0] row,
                                                input logic [RXN_W-1:0] rxn);
      logic [X_W-1:0] res;
      unique case (rxn)
         RXN_ELASTIC:   res = X_W'(row[V_W-1:0]);
         RXN_INELASTIC: res = X_W'(row[2*V_W-1:V_W]);
         RXN_FISSION:   res = X_W'(row[3*V_W-1:2*V_W]);
         RXN_CAPTURE:   res = X_W'(row[4*V_W-1:3*V_W]);
         default:       res = row[VROW_W-1:4*V_W];
      endcase
      return res;
   endfunction

   function automatic logic [CNT_W-1:0] active_points(input logic [PTS_W-1:0] pts);
      int n;
      n = int'(pts);
      if (n < 2) n = 2;
      if (n > GRID_DEPTH) n = GRID_DEPTH;
      return CNT_W'(n);
   endfunction

endpackage

// ----- src/xs_grid_interpolation_lookup.sv -----
// load word: written in the cycle it is accepted, next word taken the cycle after
// lookup clamped at the grid ends: L_FIRST, L_LAST, L_CLAMP, then L_OUT, which waits while the output stalls
// lookup interpolated: L_FIRST, L_LAST, a memory read in L_SRCH and compare in L_CMP per search step,
// then L_LO, L_HI, L_PREP, the 34-step multiply and divide in L_MULDIV unless the interval is flat, and L_OUT
// one lookup in flight; the next word is taken while a result waits at the output
// reset clears control and sets points_ff to 2; grid memories hold nothing until loaded
module xs_grid_interpolation_lookup
   import xsgil_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [9:0]          req_point_index,
   input  logic [E_W-1:0]      req_energy,
   input  logic [V_W-1:0]      req_elastic_value,
   input  logic [V_W-1:0]      req_inelastic_value,
   input  logic [V_W-1:0]      req_fission_value,
   input  logic [V_W-1:0]      req_capture_value,
   input  logic [RXN_W-1:0]    req_reaction,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BIN_W-1:0]    rsp_bin_index,
   output logic [X_W-1:0]      rsp_cross_section,
   output logic [FLAG_W-1:0]   rsp_range_flag,
   input  logic                csr_wr_en,
   input  logic [PTS_W-1:0]    csr_wr_data
);

   lookup_state_type state_ff, state_in;

   logic [PTS_W-1:0]  points_ff;
   logic [E_W-1:0]    energy_ff;
   logic [RXN_W-1:0]  reaction_ff;
   logic [CNT_W-1:0]  n_ff;
   logic              below_ff;
   logic [CNT_W-1:0]  first_ff, count_ff;
   logic [IDX_W-1:0]  bin_ff;
   logic [E_W-1:0]    el_ff, eh_ff;
   logic [X_W-1:0]    xl_ff, xh_ff, xs_ff;
   logic [FLAG_W-1:0] flag_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]  rsp_bin_ff;
   logic [X_W-1:0]    rsp_xs_ff;
   logic [FLAG_W-1:0] rsp_flag_ff;

   logic              accept, load_accept, lookup_accept, out_free, load_out;
   logic [CNT_W-1:0]  step, probe, first_clamp;
   logic [IDX_W-1:0]  bin_calc;
   logic [E_W-1:0]    grid_rd_data;
   logic [VROW_W-1:0] val_rd_data, val_wr_data;
   logic              grid_rd_en, val_rd_en, wr_en;
   logic [IDX_W-1:0]  grid_rd_addr, val_rd_addr, wr_addr;
   logic [X_W-1:0]    total;
   logic              md_start, md_done;
   logic [X_W-1:0]    md_q, mag;
   logic [E_W-1:0]    den, t_raw, t_clip;

   assign req_stall     = (state_ff != L_IDLE);
   assign accept        = req_valid && !req_stall;
   assign load_accept   = accept && (req_mode == MODE_LOAD);
   assign lookup_accept = accept && (req_mode == MODE_LOOKUP);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign load_out      = (state_ff == L_OUT) && out_free;

   // ---- storage ----
   assign total = X_W'(req_elastic_value) + X_W'(req_inelastic_value)
                + X_W'(req_fission_value) + X_W'(req_capture_value);
   assign val_wr_data = {total, req_capture_value, req_fission_value,
                         req_inelastic_value, req_elastic_value};
   assign wr_en   = load_accept && (int'(req_point_index) < GRID_DEPTH);
   assign wr_addr = IDX_W'(req_point_index);

   xsgil_ram #(.WIDTH(E_W), .DEPTH(GRID_DEPTH)) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_energy),
      .rd_en   (grid_rd_en),
      .rd_addr (grid_rd_addr),
      .rd_data (grid_rd_data)
   );

   xsgil_ram #(.WIDTH(VROW_W), .DEPTH(GRID_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (val_rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   // ---- search helpers ----
   assign step  = count_ff >> 1;
   assign probe = first_ff + step;

   always_comb begin
      first_clamp = first_ff;
      if (first_clamp < CNT_W'(1)) first_clamp = CNT_W'(1);
      if (first_clamp > n_ff - 1'b1) first_clamp = n_ff - 1'b1;
   end
   assign bin_calc = IDX_W'(first_clamp - 1'b1);

   // ---- interpolation operands ----
   assign den    = eh_ff - el_ff;
   assign t_raw  = (energy_ff <= el_ff) ? '0 : energy_ff - el_ff;
   assign t_clip = (t_raw > den) ? den : t_raw;
   assign mag    = (xh_ff >= xl_ff) ? xh_ff - xl_ff : xl_ff - xh_ff;

   xsgil_muldiv u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .mag      (mag),
      .t        (t_clip),
      .den      (den),
      .done     (md_done),
      .quotient (md_q)
   );

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         L_IDLE:   if (lookup_accept) state_in = L_FIRST;
         L_FIRST:  state_in = L_LAST;
         L_LAST: begin
            if (below_ff || grid_rd_data <= energy_ff) state_in = L_CLAMP;
            else state_in = L_SRCH;
         end
         L_SRCH:   state_in = (count_ff == '0) ? L_LO : L_CMP;
         L_CMP:    state_in = L_SRCH;
         L_LO:     state_in = L_HI;
         L_HI:     state_in = L_PREP;
         L_PREP:   state_in = (eh_ff <= el_ff) ? L_OUT : L_MULDIV;
         L_MULDIV: if (md_done) state_in = L_OUT;
         L_CLAMP:  state_in = L_OUT;
         L_OUT:    if (out_free) state_in = L_IDLE;
         default:  state_in = L_IDLE;
      endcase
   end

   // ---- memory and unit control ----
   always_comb begin
      grid_rd_en   = 1'b0;
      grid_rd_addr = '0;
      val_rd_en    = 1'b0;
      val_rd_addr  = '0;
      md_start     = 1'b0;
      unique case (state_ff)
         L_IDLE: begin
            grid_rd_en = lookup_accept;
         end
         L_FIRST: begin
            grid_rd_en   = 1'b1;
            grid_rd_addr = IDX_W'(n_ff - 1'b1);
         end
         L_LAST: begin
            val_rd_en   = 1'b1;
            val_rd_addr = below_ff ? '0 : IDX_W'(n_ff - 1'b1);
         end
         L_SRCH: begin
            grid_rd_en = 1'b1;
            if (count_ff != '0) begin
               grid_rd_addr = IDX_W'(probe);
            end else begin
               grid_rd_addr = bin_calc;
               val_rd_en    = 1'b1;
               val_rd_addr  = bin_calc;
            end
         end
         L_LO: begin
            grid_rd_en   = 1'b1;
            grid_rd_addr = bin_ff + 1'b1;
            val_rd_en    = 1'b1;
            val_rd_addr  = bin_ff + 1'b1;
         end
         L_PREP: begin
            md_start = (eh_ff > el_ff);
         end
         default: ;
      endcase
   end

   // ---- datapath ----
   always_ff @(posedge clock) begin
      unique case (state_ff)
         L_IDLE: begin
            if (lookup_accept) begin
               energy_ff   <= req_energy;
               reaction_ff <= req_reaction;
               n_ff        <= active_points(points_ff);
            end
         end
         L_FIRST: begin
            below_ff <= (energy_ff <= grid_rd_data);
         end
         L_LAST: begin
            if (below_ff) begin
               bin_ff  <= '0;
               flag_ff <= FLAG_BELOW;
            end else if (grid_rd_data <= energy_ff) begin
               bin_ff  <= IDX_W'(n_ff - CNT_W'(2));
               flag_ff <= FLAG_ABOVE;
            end else begin
               flag_ff <= FLAG_INTERP;
            end
            first_ff <= '0;
            count_ff <= n_ff;
         end
         L_SRCH: begin
            if (count_ff == '0) bin_ff <= bin_calc;
         end
         L_CMP: begin
            if (grid_rd_data < energy_ff) begin
               first_ff <= probe + 1'b1;
               count_ff <= count_ff - step - 1'b1;
            end else begin
               count_ff <= step;
            end
         end
         L_LO: begin
            el_ff <= grid_rd_data;
            xl_ff <= xs_select(val_rd_data, reaction_ff);
         end
         L_HI: begin
            eh_ff <= grid_rd_data;
            xh_ff <= xs_select(val_rd_data, reaction_ff);
         end
         L_PREP: begin
            if (eh_ff <= el_ff) xs_ff <= xl_ff;
         end
         L_MULDIV: begin
            if (md_done) xs_ff <= (xh_ff >= xl_ff) ? xl_ff + md_q : xl_ff - md_q;
         end
         L_CLAMP: begin
            xs_ff <= xs_select(val_rd_data, reaction_ff);
         end
         default: ;
      endcase
   end

   // ---- output word and register ----
   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= L_IDLE;
         rsp_valid_ff <= 1'b0;
         points_ff    <= PTS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) points_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_bin_ff  <= BIN_W'(bin_ff);
         rsp_xs_ff   <= xs_ff;
         rsp_flag_ff <= flag_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_index     = rsp_bin_ff;
   assign rsp_cross_section = rsp_xs_ff;
   assign rsp_range_flag    = rsp_flag_ff;

   a_out_loads : assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid)
      else $error("finished lookup did not reach the output");

   a_flag_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_range_flag == FLAG_INTERP || rsp_range_flag == FLAG_BELOW
                     || rsp_range_flag == FLAG_ABOVE))
      else $error("bad range flag on output");

   a_probe_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == L_SRCH && count_ff != '0) |-> probe < n_ff)
      else $error("search probe beyond active points");

   a_bin_range : assert property (@(posedge clock) disable iff (reset)
      state_ff == L_LO |-> CNT_W'(bin_ff) <= n_ff - CNT_W'(2))
      else $error("bin beyond last interval");

endmodule

// ----- src/xsgil_ram.sv -----
module xsgil_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/xsgil_muldiv.sv -----
module xsgil_muldiv
   import xsgil_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [X_W-1:0] mag,
   input  logic [E_W-1:0] t,
   input  logic [E_W-1:0] den,
   output logic           done,
   output logic [X_W-1:0] quotient
);

   muldiv_state_type state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [X_W-1:0]    mag_ff, mag_in;
   logic [E_W-1:0]    t_ff, t_in;
   logic [E_W-1:0]    den_ff, den_in;
   logic              last_step;
   logic [E_W:0]      trial;
   logic              ge;

   assign last_step = (cnt_ff == STEP_W'(X_W - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MD_IDLE: if (start) state_in = MD_MUL;
         MD_MUL:  if (last_step) state_in = MD_DIV;
         MD_DIV:  if (last_step) state_in = MD_DONE;
         MD_DONE: state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   always_comb begin
      done     = (state_ff == MD_DONE);
      quotient = acc_ff[X_W-1:0];
   end

   // long division: high part of the product is already below den
   assign trial = {acc_ff[PROD_W-1:X_W], acc_ff[X_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      mag_in = mag_ff;
      t_in   = t_ff;
      den_in = den_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (start) begin
               cnt_in = '0;
               acc_in = '0;
               mag_in = mag;
               t_in   = t;
               den_in = den;
            end
         end
         MD_MUL: begin
            acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                   + (mag_ff[X_W-1] ? PROD_W'(t_ff) : PROD_W'(0));
            mag_in = {mag_ff[X_W-2:0], 1'b0};
            cnt_in = last_step ? '0 : cnt_ff + 1'b1;
         end
         MD_DIV: begin
            acc_in = {(ge ? E_W'(trial - {1'b0, den_ff}) : trial[E_W-1:0]),
                      acc_ff[X_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mag_ff <= mag_in;
      t_ff   <= t_in;
      den_ff <= den_in;
   end

   a_start_args : assert property (@(posedge clock) disable iff (reset)
      start |-> (den != '0) && (t <= den))
      else $error("muldiv started with bad operands");

   a_start_mul : assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == MD_IDLE) |=> state_ff == MD_MUL)
      else $error("muldiv did not begin multiply");

   a_rem_below : assert property (@(posedge clock) disable iff (reset)
      state_ff == MD_DIV |-> acc_ff[PROD_W-1:X_W] < den_ff)
      else $error("partial remainder not below divisor");

endmodule
